@@ design/knn_topk_distance_insert_assert.svh @@
// ----------------------------------------------------------------------------
// knn_topk_distance_insert_assert.svh
// Assertion macros used by the checker of the k-nearest list keeper.
// ----------------------------------------------------------------------------
// Each macro expects i_clk in the scope that uses it; the first two also i_rst_n.
`ifndef KNN_TOPK_DISTANCE_INSERT_ASSERT_SVH
`define KNN_TOPK_DISTANCE_INSERT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define KNNTK_AST_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("knntk: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define KNNTK_AST_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("knntk: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define KNNTK_AST_ALWAYS(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("knntk: reset check failed");

`endif

@@ design/knntk_pkg.sv @@
// ----------------------------------------------------------------------------
// knntk_pkg
// Types, field widths and codes of the k-nearest list keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package knntk_pkg;

    // field widths
    localparam int DIST_W   = 48;
    localparam int LABEL_W  = 20;
    localparam int QIDX_W   = 10;
    localparam int RANK_W   = 3;
    localparam int CMD_W    = 2;
    localparam int KCFG_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 48;

    // at most this many entries leave the block on one read
    localparam int READ_CAP = 8;

    // parameter defaults
    localparam int MAX_NEIGHBOURS_DEF = 8;
    localparam int QUERY_POINTS_DEF   = 1024;
    localparam int COORD_BITS_DEF     = 16;

    // register reset values
    localparam logic [KCFG_W-1:0] K_IN_USE_RST = 4'd8;
    localparam logic [DIST_W-1:0] EMPTY_DIST_RST = 48'd1000000;

    // output tdata layout: rank, distance, label
    localparam int OUT_RANK_LSB  = 0;
    localparam int OUT_DIST_LSB  = OUT_RANK_LSB + RANK_W;
    localparam int OUT_LABEL_LSB = OUT_DIST_LSB + DIST_W;
    localparam int OUT_USED_W    = OUT_LABEL_LSB + LABEL_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K_IN_USE   = 1'b0,
        CFG_EMPTY_DIST = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ACC   = 4'b0100,
        ST_READ  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

@@ design/knn_topk_distance_insert.sv @@
// ----------------------------------------------------------------------------
// knn_topk_distance_insert
// Per-query sorted list of the k nearest candidates, by squared distance.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: query_index, candidate_label,
//                                           query_coord, candidate_coord
//                                           tuser: command, tlast: last_dim
//  m_axis    out  m_axis_tvalid/tready      tdata: rank_position, distance_sq,
//                                           neighbour_label
//                                           tuser: slot_filled, tlast: last_of_list
//  cfg       in   i_cfg_we (no wait)        i_cfg_idx, i_cfg_wdata
//
//  Accumulate: accept (with the row fetch), then one read-modify-write of the
//  query's row. Read: the row is fetched at accept, then one entry per cycle
//  while m_axis is not held, k entries. Clear: row written empty at accept.
//  Unused command or out-of-range read: done at accept.
//  The row memory is single-port: one access per cycle.
//  After reset a clearing pass writes every row empty (QUERY_POINTS rows,
//  1024 by default) with s_axis_tready low. A held m_axis stalls a read.
//
`default_nettype none

module knn_topk_distance_insert
    import knntk_pkg::*;
#(
    parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
    parameter int QUERY_POINTS   = QUERY_POINTS_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata,

    input  wire logic                    s_axis_tvalid,
    output      logic                    s_axis_tready,
    // query_index, candidate_label, query_coord, candidate_coord, zero pad
    input  wire logic [((QIDX_W + LABEL_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0]
                                         s_axis_tdata,
    // command
    input  wire logic [CMD_W-1:0]        s_axis_tuser,
    input  wire logic                    s_axis_tlast,

    output      logic                    m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // rank_position, distance_sq, neighbour_label, zero pad
    output      logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // slot_filled
    output      logic                    m_axis_tuser,
    output      logic                    m_axis_tlast
);

    localparam int KMAX    = (MAX_NEIGHBOURS < READ_CAP) ? MAX_NEIGHBOURS : READ_CAP;
    localparam int ADDR_W  = (QUERY_POINTS > 1) ? $clog2(QUERY_POINTS) : 1;
    localparam int LBL_LSB = QIDX_W;
    localparam int QC_LSB  = LBL_LSB + LABEL_W;
    localparam int CC_LSB  = QC_LSB + COORD_BITS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

    typedef struct packed {
        logic               vld;
        logic [DIST_W-1:0]  dist_sq;
        logic [LABEL_W-1:0] label;
    } t_slot;

    typedef t_slot [MAX_NEIGHBOURS-1:0] t_row;

    // configuration
    logic [KCFG_W-1:0]  r_k_in_use;
    logic [DIST_W-1:0]  r_empty;
    logic [KCFG_W-1:0]  keep;

    // control
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [RANK_W-1:0]  r_slot;

    // item held between accept and row update
    logic [ADDR_W-1:0]  r_addr;
    logic [LABEL_W-1:0] r_label;
    logic               r_last;
    logic               r_in_range;
    logic [SQ_W-1:0]    r_sq;
    logic [DIST_W-1:0]  r_acc;

    // row memory
    t_row               r_mem [QUERY_POINTS];
    t_row               r_rd_row;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    t_row               mem_wdata;

    // output register
    logic               r_m_valid;
    logic [RANK_W-1:0]  r_m_rank;
    logic [DIST_W-1:0]  r_m_dist;
    logic [LABEL_W-1:0] r_m_label;
    logic               r_m_filled;
    logic               r_m_last;
    logic               out_load;

    // input decode
    logic               in_accept;
    t_cmd               in_cmd;
    logic [QIDX_W-1:0]  in_q;
    logic               in_range;
    logic signed [COORD_BITS-1:0] in_qc, in_cc;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [SQ_W-1:0]       sq_full;

    // accumulate and insert
    logic [SUM_W-1:0]   sum_w;
    logic [DIST_W-1:0]  dist_new;
    t_row               ins_row;
    logic               ins_hit;
    logic               ins_we;

    // read slot select
    t_slot              rd_slot;
    logic               slot_last;

    // ------------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_in_use <= K_IN_USE_RST;
            r_empty    <= EMPTY_DIST_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_K_IN_USE:   r_k_in_use <= i_cfg_wdata[KCFG_W-1:0];
                CFG_EMPTY_DIST: r_empty    <= i_cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // k clamped to 1..KMAX
    always_comb begin
        if (r_k_in_use == '0) begin
            keep = KCFG_W'(1);
        end else if (r_k_in_use > KCFG_W'(KMAX)) begin
            keep = KCFG_W'(KMAX);
        end else begin
            keep = r_k_in_use;
        end
    end

    // ------------------------------------------------------------------------
    // input decode; the square is taken at accept and registered
    // ------------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = t_cmd'(s_axis_tuser);
    assign in_q          = s_axis_tdata[QIDX_W-1:0];
    assign in_range      = ({22'd0, in_q} < 32'(QUERY_POINTS));
    assign in_qc         = s_axis_tdata[QC_LSB +: COORD_BITS];
    assign in_cc         = s_axis_tdata[CC_LSB +: COORD_BITS];
    assign diff          = DIFF_W'(in_qc) - DIFF_W'(in_cc);
    assign sq_full       = diff * diff;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr     <= ADDR_W'(in_q);
            r_label    <= s_axis_tdata[LBL_LSB +: LABEL_W];
            r_last     <= s_axis_tlast;
            r_in_range <= in_range;
            r_sq       <= SQ_W'(sq_full);
        end
    end

    // ------------------------------------------------------------------------
    // saturating accumulate and sorted insert into the fetched row
    // ------------------------------------------------------------------------
    assign sum_w    = SUM_W'(r_acc) + SUM_W'(r_sq);
    assign dist_new = (|sum_w[SUM_W-1:DIST_W]) ? '1 : sum_w[DIST_W-1:0];

    always_comb begin
        logic              in_keep;
        logic              lt;
        logic [DIST_W-1:0] eff;
        ins_row = r_rd_row;
        ins_hit = 1'b0;
        for (int n = 0; n < MAX_NEIGHBOURS; n++) begin
            in_keep = (n < KMAX) && (KCFG_W'(n) < keep);
            eff     = r_rd_row[n].vld ? r_rd_row[n].dist_sq : r_empty;
            lt      = in_keep && (dist_new < eff);
            if (lt && !ins_hit) begin
                ins_row[n].vld     = 1'b1;
                ins_row[n].dist_sq = dist_new;
                ins_row[n].label   = r_label;
            end else if (ins_hit && in_keep) begin
                if (n > 0) begin
                    ins_row[n] = r_rd_row[n-1];
                end
            end
            ins_hit = ins_hit | lt;
        end
    end

    assign ins_we = r_last && r_in_range && (dist_new != '0) && ins_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_state == ST_ACC) begin
            r_acc <= r_last ? '0 : dist_new;
        end
    end

    // ------------------------------------------------------------------------
    // row memory: one access per cycle, registered read
    // ------------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
            end
            ST_IDLE: begin
                mem_addr = ADDR_W'(in_q);
                mem_we   = in_accept && in_range && (in_cmd == CMD_CLEAR);
                mem_re   = in_accept && in_range && (in_cmd != CMD_CLEAR);
            end
            ST_ACC: begin
                mem_we    = ins_we;
                mem_wdata = ins_row;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_row <= r_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    assign out_load = (r_state == ST_READ) && (!r_m_valid || m_axis_tready);
    assign slot_last = ({1'b0, r_slot} + KCFG_W'(1)) == keep;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(QUERY_POINTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_cmd == CMD_ACC) begin
                        n_state = ST_ACC;
                    end else if (in_cmd == CMD_READ && in_range) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_ACC: begin
                n_state = ST_IDLE;
            end
            ST_READ: begin
                if (out_load && slot_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_slot     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (in_accept) begin
                r_slot <= '0;
            end else if (out_load) begin
                r_slot <= r_slot + RANK_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // output register; an empty slot reads as the current empty distance
    // ------------------------------------------------------------------------
    localparam int SLOT_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

    assign rd_slot = r_rd_row[SLOT_W'(r_slot)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_rank   <= r_slot;
            r_m_dist   <= rd_slot.vld ? rd_slot.dist_sq : r_empty;
            r_m_label  <= rd_slot.vld ? rd_slot.label : '0;
            r_m_filled <= rd_slot.vld;
            r_m_last   <= slot_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), r_m_label, r_m_dist, r_m_rank};
    assign m_axis_tuser  = r_m_filled;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

@@ design/knntk_checker.sv @@
// ----------------------------------------------------------------------------
// knntk_checker
// Port-level checks on the k-nearest list keeper, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "knn_topk_distance_insert_assert.svh"

module knntk_checker
    import knntk_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [CMD_W-1:0]       s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // reset starts the clearing pass: nothing taken, nothing offered
    `KNNTK_AST_ALWAYS(a_reset_quiet, !i_rst_n, !s_axis_tready && !m_axis_tvalid)

    // accumulate holds the port for its row update cycle
    `KNNTK_AST_NEXT(a_acc_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_ACC), !s_axis_tready)

    // empty slot carries label zero
    `KNNTK_AST_SAME(a_empty_label, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[OUT_LABEL_LSB +: LABEL_W] == '0)

    // stalled item holds
    `KNNTK_AST_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind knn_topk_distance_insert knntk_checker u_knntk_checker (.*);

`default_nettype wire
